// ===== hw/rtl/adcg_pkg.sv =====
// Shared types and constants for the dominant-channel gray converter.
`timescale 1ns / 1ps

package adcg_pkg;

  localparam logic [1:0] CMD_ACCUM   = 2'd0;
  localparam logic [1:0] CMD_CONVERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned WGT_W = 6;

  localparam logic [WGT_W-1:0] WGT_BIG_0 = 6'd40;
  localparam logic [WGT_W-1:0] WGT_MID_0 = 6'd20;
  localparam logic [WGT_W-1:0] WGT_BIG_1 = 6'd50;
  localparam logic [WGT_W-1:0] WGT_MID_1 = 6'd10;
  localparam logic [WGT_W-1:0] WGT_ONE   = 6'd1;

  // Weighted sum peaks at 255 * 61 = 15555.
  localparam int unsigned WSUM_W = 14;

  // floor(x / 183) == (x * 22920) >> 22, exact for x below 74898.
  localparam int unsigned RECIP_W     = 15;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] GRAY_RECIP = 15'd22920;
  localparam int unsigned PROD_W = WSUM_W + RECIP_W;

  localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;
  localparam logic [QUOT_W-1:0] POSTER_LIMIT = 7'd85;
  localparam logic [PIX_W-1:0]  GRAY_FULL    = 8'd255;

  typedef struct packed {
    logic [WGT_W-1:0] red;
    logic [WGT_W-1:0] green;
    logic [WGT_W-1:0] blue;
  } weights_t;

endpackage

// ===== hw/rtl/adcg_chan_rank.sv =====
// Channel sum accumulators and ranking into per-channel weights.
`timescale 1ns / 1ps

module adcg_chan_rank #(
  parameter int unsigned SUM_W = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [1:0]                cmd_i,
  input  logic [adcg_pkg::PIX_W-1:0] red_i,
  input  logic [adcg_pkg::PIX_W-1:0] green_i,
  input  logic [adcg_pkg::PIX_W-1:0] blue_i,
  input  logic                      weight_set_i,
  output adcg_pkg::weights_t        weights_o
);

  logic [SUM_W-1:0] red_sum_q, green_sum_q, blue_sum_q;
  logic [SUM_W-1:0] red_sum_d, green_sum_d, blue_sum_d;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [adcg_pkg::PIX_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {{(SUM_W + 1 - adcg_pkg::PIX_W){1'b0}}, v};
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  always_comb begin
    red_sum_d   = red_sum_q;
    green_sum_d = green_sum_q;
    blue_sum_d  = blue_sum_q;
    if (accept_i) begin
      if (cmd_i == adcg_pkg::CMD_ACCUM) begin
        red_sum_d   = sat_add(red_sum_q, red_i);
        green_sum_d = sat_add(green_sum_q, green_i);
        blue_sum_d  = sat_add(blue_sum_q, blue_i);
      end else if (cmd_i == adcg_pkg::CMD_CLEAR) begin
        red_sum_d   = '0;
        green_sum_d = '0;
        blue_sum_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
    end else begin
      red_sum_q   <= red_sum_d;
      green_sum_q <= green_sum_d;
      blue_sum_q  <= blue_sum_d;
    end
  end

  logic [adcg_pkg::WGT_W-1:0] big, mid;
  logic rg_ge, rb_ge, gb_ge;

  assign big   = weight_set_i ? adcg_pkg::WGT_BIG_1 : adcg_pkg::WGT_BIG_0;
  assign mid   = weight_set_i ? adcg_pkg::WGT_MID_1 : adcg_pkg::WGT_MID_0;
  assign rg_ge = red_sum_q >= green_sum_q;
  assign rb_ge = red_sum_q >= blue_sum_q;
  assign gb_ge = green_sum_q >= blue_sum_q;

  // Second place: strictly larger wins, ties go to the later channel.
  always_comb begin
    priority if (rb_ge && rg_ge) begin
      weights_o.red   = big;
      weights_o.green = gb_ge && (green_sum_q != blue_sum_q) ? mid : adcg_pkg::WGT_ONE;
      weights_o.blue  = gb_ge && (green_sum_q != blue_sum_q) ? adcg_pkg::WGT_ONE : mid;
    end else if (!rg_ge && gb_ge) begin
      weights_o.green = big;
      weights_o.red   = rb_ge && (red_sum_q != blue_sum_q) ? mid : adcg_pkg::WGT_ONE;
      weights_o.blue  = rb_ge && (red_sum_q != blue_sum_q) ? adcg_pkg::WGT_ONE : mid;
    end else begin
      weights_o.blue  = big;
      weights_o.red   = rg_ge && (red_sum_q != green_sum_q) ? mid : adcg_pkg::WGT_ONE;
      weights_o.green = rg_ge && (red_sum_q != green_sum_q) ? adcg_pkg::WGT_ONE : mid;
    end
  end

endmodule

// ===== hw/rtl/adaptive_dominant_channel_gray.sv =====
// Top level of the dominant-channel gray converter.
`timescale 1ns / 1ps
//
// Input channel (in_valid_i / in_ready_o) carries one command transaction:
// cmd_i = accumulate adds red/green/blue into the channel sums, clear zeroes
// them, convert produces one gray transaction; the unused code is dropped.
// Output channel (gray_valid_o / gray_ready_i) carries gray_o for converts only.
// weight_set_we_i loads weight_set_i; only write it while idle (not enforced).
// Ranking for a convert uses the sums left by all earlier transactions.
// A convert passes the chain input register, weighted sum register and output
// register in that order, each holding one convert. Throughput: one transaction
// per cycle while the receiver does not stall the output.
// A stalled receiver fills the three stages, then in_ready_o drops;
// accumulate and clear still need a free input stage to be taken.
// Reset clears the sums, weight_set and all stage valid flags.
//
module adaptive_dominant_channel_gray #(
  parameter int unsigned PIXEL_COUNT_BITS = 22
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       weight_set_we_i,
  input  logic       weight_set_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       gray_valid_o,
  input  logic       gray_ready_i,
  output logic [7:0] gray_o
);

  localparam int unsigned SUM_W = PIXEL_COUNT_BITS + adcg_pkg::PIX_W;
  localparam int unsigned PW = adcg_pkg::PIX_W;
  localparam int unsigned WW = adcg_pkg::WGT_W;
  localparam int unsigned SW = adcg_pkg::WSUM_W;

  logic weight_set_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_set_q <= 1'b0;
    end else if (weight_set_we_i) begin
      weight_set_q <= weight_set_i;
    end
  end

  logic accept;
  adcg_pkg::weights_t weights;

  adcg_chan_rank #(
    .SUM_W(SUM_W)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .weight_set_i(weight_set_q),
    .weights_o   (weights)
  );

  // Stage valids and flow control
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic out_free, s2_free, s1_free;

  assign out_free   = !out_vld_q || gray_ready_i;
  assign s2_free    = !s2_vld_q || out_free;
  assign s1_free    = !s1_vld_q || s2_free;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free) s1_vld_q <= accept && (cmd_i == adcg_pkg::CMD_CONVERT);
      if (s2_free) s2_vld_q <= s1_vld_q;
      if (out_free) out_vld_q <= s2_vld_q;
    end
  end

  // Stage 1: pixel and weights
  logic [PW-1:0] red_q, green_q, blue_q;
  adcg_pkg::weights_t weights_q;

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      red_q     <= red_i;
      green_q   <= green_i;
      blue_q    <= blue_i;
      weights_q <= weights;
    end
  end

  // Stage 2: weighted sum
  logic [SW-1:0] wsum_d, wsum_q;
  logic [PW+WW-1:0] pr, pg, pb;

  assign pr     = {{WW{1'b0}}, red_q} * {{PW{1'b0}}, weights_q.red};
  assign pg     = {{WW{1'b0}}, green_q} * {{PW{1'b0}}, weights_q.green};
  assign pb     = {{WW{1'b0}}, blue_q} * {{PW{1'b0}}, weights_q.blue};
  assign wsum_d = {{(SW-PW-WW){1'b0}}, pr} + {{(SW-PW-WW){1'b0}}, pg}
                + {{(SW-PW-WW){1'b0}}, pb};

  always_ff @(posedge clk_i) begin
    if (s2_free) wsum_q <= wsum_d;
  end

  // Output stage: divide by 183 via reciprocal, then posterise
  logic [adcg_pkg::PROD_W-1:0] prod;
  logic [adcg_pkg::QUOT_W-1:0] quot;
  logic [PW:0] trip;
  logic [PW-1:0] gray_d, gray_q;

  assign prod = {{adcg_pkg::RECIP_W{1'b0}}, wsum_q}
              * {{SW{1'b0}}, adcg_pkg::GRAY_RECIP};
  assign quot = prod[adcg_pkg::PROD_W-1:adcg_pkg::RECIP_SHIFT];
  assign trip = {{(PW + 1 - adcg_pkg::QUOT_W){1'b0}}, quot}
              + {{(PW - adcg_pkg::QUOT_W){1'b0}}, quot, 1'b0};
  assign gray_d = (quot > adcg_pkg::POSTER_LIMIT) ? adcg_pkg::GRAY_FULL : trip[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (out_free) gray_q <= gray_d;
  end

  assign gray_valid_o = out_vld_q;
  assign gray_o       = gray_q;

endmodule

// ===== sim/adaptive_dominant_channel_gray_tb.sv =====
// Self-checking testbench for the dominant-channel gray converter.
`timescale 1ns / 1ps

module adaptive_dominant_channel_gray_tb;

  localparam logic [1:0]  CMD_SPARE     = 2'd3;
  localparam int unsigned GRAY_DIV      = 183;
  localparam logic [30:0] SUM_MAX       = 31'h3FFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 142;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  class gray_scoreboard;
    logic [29:0] red_total;
    logic [29:0] green_total;
    logic [29:0] blue_total;
    logic        weight_sel;
    logic [7:0]  gray_due[$];
    int unsigned mismatches;
    int unsigned n_accum;
    int unsigned n_convert;
    int unsigned n_clear;
    int unsigned n_dropped;
    int unsigned n_checked;

    function new();
      red_total   = '0;
      green_total = '0;
      blue_total  = '0;
      weight_sel  = 1'b0;
      mismatches  = 0;
      n_accum     = 0;
      n_convert   = 0;
      n_clear     = 0;
      n_dropped   = 0;
      n_checked   = 0;
    endfunction

    function void set_weights(logic sel);
      weight_sel = sel;
    endfunction

    function int pending();
      return gray_due.size();
    endfunction

    function logic [29:0] sat_add(logic [29:0] total, logic [7:0] v);
      logic [30:0] t;
      t = {1'b0, total} + v;
      return (t > SUM_MAX) ? SUM_MAX[29:0] : t[29:0];
    endfunction

    function logic [7:0] predict_gray(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned big, mid, wr, wg, wb, wsum, quot;
      big = weight_sel ? adcg_pkg::WGT_BIG_1 : adcg_pkg::WGT_BIG_0;
      mid = weight_sel ? adcg_pkg::WGT_MID_1 : adcg_pkg::WGT_MID_0;
      if (red_total >= blue_total && red_total >= green_total) begin
        wr = big;
        if (green_total > blue_total) begin
          wg = mid;
          wb = adcg_pkg::WGT_ONE;
        end else begin
          wg = adcg_pkg::WGT_ONE;
          wb = mid;
        end
      end else if (green_total >= red_total && green_total >= blue_total) begin
        wg = big;
        if (red_total > blue_total) begin
          wr = mid;
          wb = adcg_pkg::WGT_ONE;
        end else begin
          wr = adcg_pkg::WGT_ONE;
          wb = mid;
        end
      end else begin
        wb = big;
        if (red_total > green_total) begin
          wr = mid;
          wg = adcg_pkg::WGT_ONE;
        end else begin
          wr = adcg_pkg::WGT_ONE;
          wg = mid;
        end
      end
      wsum = r * wr + g * wg + b * wb;
      quot = wsum / GRAY_DIV;
      if (quot > adcg_pkg::POSTER_LIMIT) return adcg_pkg::GRAY_FULL;
      return 8'(quot * 3);
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      case (cmd)
        adcg_pkg::CMD_ACCUM: begin
          red_total   = sat_add(red_total, r);
          green_total = sat_add(green_total, g);
          blue_total  = sat_add(blue_total, b);
          n_accum++;
        end
        adcg_pkg::CMD_CONVERT: begin
          gray_due.push_back(predict_gray(r, g, b));
          n_convert++;
        end
        adcg_pkg::CMD_CLEAR: begin
          red_total   = '0;
          green_total = '0;
          blue_total  = '0;
          n_clear++;
        end
        default: n_dropped++;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_gray(logic [7:0] got);
      logic [7:0] want;
      if (gray_due.size() == 0) begin
        report_mismatch($sformatf("gray %0d with no convert outstanding", got));
      end else begin
        want = gray_due.pop_front();
        n_checked++;
        if (got !== want)
          report_mismatch($sformatf("gray got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       weight_set_we_i;
  logic       weight_set_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] cmd_i;
  logic [7:0] red_i;
  logic [7:0] green_i;
  logic [7:0] blue_i;
  logic       gray_valid_o;
  logic       gray_ready_i;
  logic [7:0] gray_o;

  gray_scoreboard sb = new();
  bit          calm = 1'b0;
  int unsigned counted_items = 0;
  int unsigned cycles = 0;

  adaptive_dominant_channel_gray u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .weight_set_we_i(weight_set_we_i),
    .weight_set_i   (weight_set_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .gray_valid_o   (gray_valid_o),
    .gray_ready_i   (gray_ready_i),
    .gray_o         (gray_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (gray_valid_o && gray_ready_i) sb.check_gray(gray_o);
  end

  // receiver back-pressure
  initial begin
    gray_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gray_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        gray_ready_i <= 1'b1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_pixel(input logic [1:0] cmd, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, r, g, b);
    if (cmd != CMD_SPARE) counted_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_weight_set(input logic sel);
    weight_set_we_i <= 1'b1;
    weight_set_i    <= sel;
    @(negedge clk_i);
    weight_set_we_i <= 1'b0;
    sb.set_weights(sel);
  endtask

  function automatic logic [7:0] pick_cap();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1, 2:    return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // one image: optional clear, accumulate pass, convert pass; sometimes scrambled
  task automatic run_frame();
    int unsigned n_acc, n_conv, tie_mode, k;
    logic [7:0]  cap_r, cap_g, cap_b, r, g, b;
    logic [1:0]  cmd;
    bit          broken;
    n_acc    = $urandom_range(1, 12);
    n_conv   = $urandom_range(1, 12);
    tie_mode = $urandom_range(0, 9);
    broken   = ($urandom_range(0, 5) == 0);
    cap_r    = pick_cap();
    cap_g    = pick_cap();
    cap_b    = pick_cap();
    if ($urandom_range(0, 4) != 0)
      send_pixel(adcg_pkg::CMD_CLEAR, pick_channel(), pick_channel(), pick_channel());
    for (k = 0; k < n_acc + n_conv; k++) begin
      if (broken) begin
        case ($urandom_range(0, 19))
          0:       cmd = adcg_pkg::CMD_CLEAR;
          1:       cmd = CMD_SPARE;
          default: cmd = $urandom_range(0, 1) ? adcg_pkg::CMD_CONVERT : adcg_pkg::CMD_ACCUM;
        endcase
      end else begin
        cmd = (k < n_acc) ? adcg_pkg::CMD_ACCUM : adcg_pkg::CMD_CONVERT;
        if ($urandom_range(0, 11) == 0)
          send_pixel(CMD_SPARE, pick_channel(), pick_channel(), pick_channel());
      end
      if (cmd == adcg_pkg::CMD_ACCUM) begin
        r = 8'($urandom_range(0, cap_r));
        g = 8'($urandom_range(0, cap_g));
        b = 8'($urandom_range(0, cap_b));
        case (tie_mode)
          0: g = r;
          1: b = g;
          2: b = r;
          3: begin
            g = r;
            b = r;
          end
          default: ;
        endcase
      end else begin
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
      end
      send_pixel(cmd, r, g, b);
    end
  endtask

  initial begin
    int unsigned phase, phase_end;
    rst_ni          = 1'b0;
    weight_set_we_i = 1'b0;
    weight_set_i    = 1'b0;
    in_valid_i      = 1'b0;
    cmd_i           = adcg_pkg::CMD_ACCUM;
    red_i           = '0;
    green_i         = '0;
    blue_i          = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_weight_set(1'b0);

    // ranking corners and tie rules, field extremes, dropped command
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd255, 8'd255, 8'd255);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd0, 8'd0, 8'd0);
    send_pixel(CMD_SPARE, 8'd255, 8'd255, 8'd255);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd0, 8'd255, 8'd0);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd255, 8'd0, 8'd0);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd0, 8'd0, 8'd255);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd200, 8'd0, 8'd0);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd10, 8'd200, 8'd100);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd0, 8'd0, 8'd255);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd100, 8'd50, 8'd255);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd0, 8'd0, 8'd10);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd1, 8'd254, 8'd128);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd100, 8'd0, 8'd0);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd128, 8'd127, 8'd1);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd0, 8'd20, 8'd0);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd255, 8'd255, 8'd0);
    send_pixel(adcg_pkg::CMD_CLEAR, 8'd170, 8'd85, 8'd255);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd0, 8'd255, 8'd255);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd0, 8'd0, 8'd0);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd255, 8'd255, 8'd255);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd17, 8'd34, 8'd200);
    send_pixel(adcg_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd5, 8'd5, 8'd9);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd90, 8'd90, 8'd90);
    send_pixel(adcg_pkg::CMD_ACCUM, 8'd5, 8'd5, 8'd0);
    send_pixel(adcg_pkg::CMD_CONVERT, 8'd3, 8'd3, 8'd3);

    for (phase = 1; phase <= NUM_PHASES; phase++) begin
      drain_and_settle();
      write_weight_set(phase[0]);
      if (phase == NUM_PHASES) calm = 1'b1;
      phase_end = counted_items + PHASE_ITEMS;
      while (counted_items < phase_end) run_frame();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d transactions taken: %0d accumulate, %0d convert, %0d clear, %0d dropped",
             sb.n_accum + sb.n_convert + sb.n_clear + sb.n_dropped, sb.n_accum, sb.n_convert,
             sb.n_clear, sb.n_dropped);
    $display("%0d gray results checked over both weight sets, %0d mismatches",
             sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
